// ----- rtl/tfs_pkg.sv -----
// tfs_pkg: shared constants, types and helpers for the telemetry frame stuffer
// frame byte values, escape codes, register map and frame/config types
// no dependencies
package tfs_pkg;

   localparam int FRAME_BYTES = 8;
   localparam int BYTE_IDX_W  = $clog2(FRAME_BYTES);
   localparam int SUM_W       = 11;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [7:0] FLAG_BYTE      = 8'h7E;
   localparam logic [7:0] ESC_BYTE       = 8'h7D;
   localparam logic [7:0] FLAG_SUBST     = 8'h5E;
   localparam logic [7:0] ESC_SUBST      = 8'h5D;
   localparam logic [7:0] CHECK_BASE     = 8'hFF;
   localparam logic [7:0] STUFF_BYTE_RST = 8'h7D;
   localparam logic [7:0] FRAME_TYPE_RST = 8'h10;

   typedef enum logic {
      REG_STUFF_BYTE = 1'b0,
      REG_FRAME_TYPE = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [7:0] stuff_byte;
      logic [7:0] frame_type_byte;
   } cfg_regs_type;

   typedef logic [FRAME_BYTES-1:0][7:0] frame_bytes_type;

   function automatic logic is_special(input logic [7:0] b);
      return (b == FLAG_BYTE) || (b == ESC_BYTE);
   endfunction

   function automatic logic [7:0] subst_of(input logic [7:0] b);
      return (b == FLAG_BYTE) ? FLAG_SUBST : ESC_SUBST;
   endfunction

endpackage

// ----- rtl/tfs_csr.sv -----
// tfs_csr: apb-style configuration registers (stuff byte, frame type byte)
// depends on tfs_pkg
module tfs_csr
   import tfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_regs_type          cfg
);

   cfg_regs_type  cfg_ff;
   cfg_regs_type  cfg_in;
   reg_index_type reg_sel;
   logic          wr_en;

   assign reg_sel    = reg_index_type'(csr_paddr[2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_STUFF_BYTE: cfg_in.stuff_byte      = csr_pwdata[7:0];
            REG_FRAME_TYPE: cfg_in.frame_type_byte = csr_pwdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_STUFF_BYTE: csr_prdata = {{(CSR_DATA_W-8){1'b0}}, cfg_ff.stuff_byte};
         REG_FRAME_TYPE: csr_prdata = {{(CSR_DATA_W-8){1'b0}}, cfg_ff.frame_type_byte};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stuff_byte      <= STUFF_BYTE_RST;
         cfg_ff.frame_type_byte <= FRAME_TYPE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/tfs_frame_pipe.sv -----
// tfs_frame_pipe: three-stage frame builder (capture, byte sum, fold and check byte)
// depends on tfs_pkg
module tfs_frame_pipe
   import tfs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_stall,
   input  logic [15:0]     in_data_id,
   input  logic [31:0]     in_value,
   input  logic [7:0]      frame_type_byte,
   output logic            out_valid,
   input  logic            out_stall,
   output frame_bytes_type out_frame
);

   logic            v1_ff, v2_ff, v3_ff;
   logic            v1_in, v2_in, v3_in;
   logic            adv1, adv2, adv3;

   frame_bytes_type frame1_ff, frame2_ff, frame3_ff;
   logic [SUM_W-1:0] sum2_ff;
   logic [SUM_W-1:0] sum2_in;

   logic [8:0]      fold_a;
   logic [7:0]      fold_b;
   frame_bytes_type frame3_in;

   assign adv3 = !v3_ff || !out_stall;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;

   assign v1_in = adv1 ? in_valid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;

   assign in_stall  = !adv1;
   assign out_valid = v3_ff;
   assign out_frame = frame3_ff;

   // plain byte sum of the seven bytes ahead of the check byte
   always_comb begin
      sum2_in = '0;
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
         sum2_in = sum2_in + {{(SUM_W-8){1'b0}}, frame1_ff[i]};
      end
   end

   // end-around carry fold, same as folding after every byte
   always_comb begin
      fold_a    = {1'b0, sum2_ff[7:0]} + {6'b0, sum2_ff[SUM_W-1:8]};
      fold_b    = fold_a[7:0] + {7'b0, fold_a[8]};
      frame3_in = frame2_ff;
      frame3_in[FRAME_BYTES-1] = CHECK_BASE - fold_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         frame1_ff <= {8'h00, in_value[31:24], in_value[23:16], in_value[15:8],
                       in_value[7:0], in_data_id[15:8], in_data_id[7:0],
                       frame_type_byte};
      end
      if (adv2) begin
         frame2_ff <= frame1_ff;
         sum2_ff   <= sum2_in;
      end
      if (adv3) begin
         frame3_ff <= frame3_in;
      end
   end

endmodule

// ----- rtl/tfs_escaper.sv -----
// tfs_escaper: byte serialiser with escape insertion and last-byte marking
// depends on tfs_pkg
module tfs_escaper
   import tfs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [7:0]      stuff_byte,
   input  logic            in_valid,
   output logic            in_stall,
   input  frame_bytes_type in_frame,
   output logic            out_valid,
   input  logic            out_stall,
   output logic [7:0]      out_byte,
   output logic            out_last
);

   frame_bytes_type       frame_ff, frame_in;
   logic [BYTE_IDX_W-1:0] idx_ff, idx_in;
   logic                  pair_ff, pair_in;
   logic                  busy_ff, busy_in;

   logic [7:0] cur;
   logic       special;
   logic       take;
   logic       free;
   logic       load;

   assign cur      = frame_ff[idx_ff];
   assign special  = is_special(cur);
   assign out_last = (idx_ff == BYTE_IDX_W'(FRAME_BYTES - 1)) && (!special || pair_ff);
   assign take     = busy_ff && !out_stall;
   assign free     = !busy_ff || (take && out_last);
   assign load     = in_valid && free;

   assign out_valid = busy_ff;
   assign in_stall  = !free;

   always_comb begin
      priority if (!special) begin
         out_byte = cur;
      end else if (!pair_ff) begin
         out_byte = stuff_byte;
      end else begin
         out_byte = subst_of(cur);
      end
   end

   always_comb begin
      frame_in = frame_ff;
      idx_in   = idx_ff;
      pair_in  = pair_ff;
      busy_in  = busy_ff;
      priority if (load) begin
         frame_in = in_frame;
         idx_in   = '0;
         pair_in  = 1'b0;
         busy_in  = 1'b1;
      end else if (take) begin
         if (special && !pair_ff) begin
            pair_in = 1'b1;
         end else begin
            pair_in = 1'b0;
            if (out_last) begin
               busy_in = 1'b0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         pair_ff <= 1'b0;
         busy_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         pair_ff <= pair_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

endmodule

// ----- rtl/telemetry_frame_stuffer_core.sv -----
// telemetry_frame_stuffer_core: top level, csr block, frame pipeline and escaper
// a request's first byte passes the capture, sum and fold registers, then the escaper
// throughput: one byte per cycle unless rsp_stall holds it, 8 to 16 bytes per request
// the three-stage front end takes a request every cycle until it fills behind the output
// reset: synchronous, clears all valid and sequencing state, stuff byte 0x7d, frame type 0x10
// depends on tfs_pkg, tfs_csr, tfs_frame_pipe, tfs_escaper
module telemetry_frame_stuffer_core
   import tfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [15:0]           req_data_id,
   input  logic [31:0]           req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last_byte,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_regs_type    cfg;
   logic            frame_valid;
   logic            frame_stall;
   frame_bytes_type frame;

   tfs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tfs_frame_pipe u_frame_pipe (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_valid),
      .in_stall        (req_stall),
      .in_data_id      (req_data_id),
      .in_value        (req_value),
      .frame_type_byte (cfg.frame_type_byte),
      .out_valid       (frame_valid),
      .out_stall       (frame_stall),
      .out_frame       (frame)
   );

   tfs_escaper u_escaper (
      .clock      (clock),
      .reset      (reset),
      .stuff_byte (cfg.stuff_byte),
      .in_valid   (frame_valid),
      .in_stall   (frame_stall),
      .in_frame   (frame),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_byte   (rsp_out_byte),
      .out_last   (rsp_last_byte)
   );

endmodule
